@@ rtl/core/jsc_pkg.sv @@
package jsc_pkg;

    localparam int KIND_W       = 4;
    localparam int PAYLOAD_W    = 64;
    localparam int OFFSET_W     = 32;
    localparam int EVENT_W      = 4;
    localparam int ERROR_W      = 4;
    localparam int DEPTH_W      = 7;
    localparam int NEST_DEPTH_DEF = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_OBJ_OPEN  = 4'd0,
        KIND_OBJ_CLOSE = 4'd1,
        KIND_ARR_OPEN  = 4'd2,
        KIND_ARR_CLOSE = 4'd3,
        KIND_COMMA     = 4'd4,
        KIND_COLON     = 4'd5,
        KIND_TRUE      = 4'd6,
        KIND_FALSE     = 4'd7,
        KIND_NULL      = 4'd8,
        KIND_INT       = 4'd9,
        KIND_FLOAT     = 4'd10,
        KIND_STR_BEGIN = 4'd11,
        KIND_STR_END   = 4'd12,
        KIND_END       = 4'd13
    } t_kind;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 4'd0,
        EV_OBJ_BEGIN = 4'd1,
        EV_OBJ_END   = 4'd2,
        EV_ARR_BEGIN = 4'd3,
        EV_ARR_END   = 4'd4,
        EV_TRUE      = 4'd5,
        EV_FALSE     = 4'd6,
        EV_NULL      = 4'd7,
        EV_INT       = 4'd8,
        EV_FLOAT     = 4'd9,
        EV_STR_BEGIN = 4'd10,
        EV_STR_END   = 4'd11
    } t_event;

    typedef enum logic [ERROR_W-1:0] {
        ERR_OK       = 4'd0,
        ERR_UCURLY   = 4'd1,
        ERR_UBRACK   = 4'd2,
        ERR_UCOMMA   = 4'd3,
        ERR_UCOLON   = 4'd4,
        ERR_XCOLON   = 4'd5,
        ERR_XKEY     = 4'd6,
        ERR_XKEYCC   = 4'd7,
        ERR_XCMCC    = 4'd8,
        ERR_XCMCB    = 4'd9,
        ERR_EXCESS   = 4'd10,
        ERR_INSUFF   = 4'd11,
        ERR_OVFL     = 4'd12,
        ERR_INTERN   = 4'd13
    } t_error;

    typedef enum logic [3:0] {
        PS_EV   = 4'd0,
        PS_MOK  = 4'd1,
        PS_EOK  = 4'd2,
        PS_ECOL = 4'd3,
        PS_MOC  = 4'd4,
        PS_EOV  = 4'd5,
        PS_MAV  = 4'd6,
        PS_EAV  = 4'd7,
        PS_MAC  = 4'd8,
        PS_DONE = 4'd9
    } t_pstate;

    // Stack level marks
    localparam logic NEST_OBJ = 1'b0;
    localparam logic NEST_ARR = 1'b1;

    typedef struct packed {
        logic push;
        logic pop;
        logic push_bit;
    } t_stk_op;

    typedef struct packed {
        logic empty;
        logic full;
        logic one;
        logic top;
        logic second;
    } t_stk_stat;

    typedef struct packed {
        t_event  ev;
        t_error  err;
        t_pstate nxt;
        t_stk_op op;
    } t_dec_res;

endpackage

@@ rtl/core/jsc_stack.sv @@
module jsc_stack #(
    parameter int NEST_DEPTH = jsc_pkg::NEST_DEPTH_DEF,
    parameter int CNT_W      = $clog2(NEST_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jsc_pkg::t_stk_op   i_op,
    output jsc_pkg::t_stk_stat o_stat,
    output logic [CNT_W-1:0]   o_count_next
);
    import jsc_pkg::*;

    localparam int SW = (NEST_DEPTH < 2) ? 2 : NEST_DEPTH;

    // Top of stack sits at bit 0; push shifts up, pop shifts down
    logic [SW-1:0]    r_bits;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_op.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_op.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_bits <= {r_bits[SW-2:0], i_op.push_bit};
        end else if (i_op.pop) begin
            r_bits <= {1'b0, r_bits[SW-1:1]};
        end
    end

    assign o_stat.empty  = (r_count == '0);
    assign o_stat.full   = (r_count == CNT_W'(NEST_DEPTH));
    assign o_stat.one    = (r_count == CNT_W'(1));
    assign o_stat.top    = r_bits[0];
    assign o_stat.second = r_bits[1];
    assign o_count_next  = n_count;

endmodule

@@ rtl/core/jsc_decode.sv @@
module jsc_decode (
    input  logic [jsc_pkg::KIND_W-1:0] i_kind,
    input  jsc_pkg::t_pstate           i_pstate,
    input  jsc_pkg::t_stk_stat         i_stat,
    output jsc_pkg::t_dec_res          o_res
);
    import jsc_pkg::*;

    t_event  ev;
    t_error  err;
    t_pstate nxt;
    t_pstate after_val;
    t_pstate close_nxt;
    logic    req_push;
    logic    push_bit;
    logic    req_close;
    logic    want;

    always_comb begin
        after_val = (i_pstate == PS_EV)  ? PS_DONE :
                    (i_pstate == PS_EOV) ? PS_MOC : PS_MAC;
        close_nxt = i_stat.one ? PS_DONE :
                    ((i_stat.second == NEST_ARR) ? PS_MAC : PS_MOC);

        ev        = EV_NONE;
        err       = ERR_OK;
        nxt       = i_pstate;
        req_push  = 1'b0;
        push_bit  = NEST_OBJ;
        req_close = 1'b0;
        want      = NEST_OBJ;

        if (i_kind == KIND_END) begin
            if (i_pstate != PS_DONE) begin
                err = ERR_INSUFF;
            end
        end else if (i_kind > KIND_END) begin
            err = ERR_INTERN;
        end else begin
            case (i_pstate)
                PS_EV, PS_EOV, PS_MAV, PS_EAV: begin
                    case (i_kind)
                        KIND_OBJ_OPEN: begin
                            req_push = 1'b1;
                            push_bit = NEST_OBJ;
                            ev       = EV_OBJ_BEGIN;
                            nxt      = PS_MOK;
                        end
                        KIND_OBJ_CLOSE: err = ERR_UCURLY;
                        KIND_ARR_OPEN: begin
                            req_push = 1'b1;
                            push_bit = NEST_ARR;
                            ev       = EV_ARR_BEGIN;
                            nxt      = PS_MAV;
                        end
                        KIND_ARR_CLOSE: begin
                            if (i_pstate == PS_MAV) begin
                                req_close = 1'b1;
                                want      = NEST_ARR;
                                ev        = EV_ARR_END;
                            end else begin
                                err = ERR_UBRACK;
                            end
                        end
                        KIND_COMMA:     err = ERR_UCOMMA;
                        KIND_COLON:     err = ERR_UCOLON;
                        KIND_STR_BEGIN: ev  = EV_STR_BEGIN;
                        KIND_TRUE: begin
                            ev  = EV_TRUE;
                            nxt = after_val;
                        end
                        KIND_FALSE: begin
                            ev  = EV_FALSE;
                            nxt = after_val;
                        end
                        KIND_NULL: begin
                            ev  = EV_NULL;
                            nxt = after_val;
                        end
                        KIND_INT: begin
                            ev  = EV_INT;
                            nxt = after_val;
                        end
                        KIND_FLOAT: begin
                            ev  = EV_FLOAT;
                            nxt = after_val;
                        end
                        KIND_STR_END: begin
                            ev  = EV_STR_END;
                            nxt = after_val;
                        end
                        default: err = ERR_INTERN;
                    endcase
                end
                PS_MOK: begin
                    case (i_kind)
                        KIND_OBJ_CLOSE: begin
                            req_close = 1'b1;
                            want      = NEST_OBJ;
                            ev        = EV_OBJ_END;
                        end
                        KIND_STR_BEGIN: ev = EV_STR_BEGIN;
                        KIND_STR_END: begin
                            ev  = EV_STR_END;
                            nxt = PS_ECOL;
                        end
                        KIND_INT, KIND_FLOAT: err = ERR_XKEYCC;
                        default: err = ERR_XKEY;
                    endcase
                end
                PS_EOK: begin
                    case (i_kind)
                        KIND_STR_BEGIN: ev = EV_STR_BEGIN;
                        KIND_STR_END: begin
                            ev  = EV_STR_END;
                            nxt = PS_ECOL;
                        end
                        default: err = ERR_XKEY;
                    endcase
                end
                PS_ECOL: begin
                    case (i_kind)
                        KIND_COLON:   nxt = PS_EOV;
                        KIND_STR_END: err = ERR_INTERN;
                        default:      err = ERR_XCOLON;
                    endcase
                end
                PS_MOC: begin
                    case (i_kind)
                        KIND_COMMA: nxt = PS_EOK;
                        KIND_OBJ_CLOSE: begin
                            req_close = 1'b1;
                            want      = NEST_OBJ;
                            ev        = EV_OBJ_END;
                        end
                        KIND_STR_END: err = ERR_INTERN;
                        default:      err = ERR_XCMCC;
                    endcase
                end
                PS_MAC: begin
                    case (i_kind)
                        KIND_COMMA: nxt = PS_EAV;
                        KIND_ARR_CLOSE: begin
                            req_close = 1'b1;
                            want      = NEST_ARR;
                            ev        = EV_ARR_END;
                        end
                        KIND_STR_END: err = ERR_INTERN;
                        default:      err = ERR_XCMCB;
                    endcase
                end
                PS_DONE: err = (i_kind == KIND_STR_END) ? ERR_INTERN : ERR_EXCESS;
                default: err = ERR_INTERN;
            endcase
        end

        if (req_push && i_stat.full) begin
            err = ERR_OVFL;
        end
        if (req_close) begin
            if (i_stat.empty || (i_stat.top != want)) begin
                err = ERR_INTERN;
            end else begin
                nxt = close_nxt;
            end
        end

        // A failing token leaves everything as it was
        if (err != ERR_OK) begin
            ev  = EV_NONE;
            nxt = i_pstate;
        end

        o_res.ev          = ev;
        o_res.err         = err;
        o_res.nxt         = nxt;
        o_res.op.push     = req_push && (err == ERR_OK);
        o_res.op.pop      = req_close && (err == ERR_OK);
        o_res.op.push_bit = push_bit;
    end

endmodule

@@ rtl/core/json_syntax_checker_top.sv @@
// JSON grammar checker: one lexer token in, one result beat out.
// Each token passes the input register, then the result register, on its way to its
// result beat. Throughput: one token per cycle while the receiver keeps taking results,
// set by the parse-state and nesting-stack update between the two registers.
// Reset (synchronous, active low) clears the parse state to expect-value,
// the depth to zero and both valid flags; the nesting bits are not cleared.
module json_syntax_checker_top #(
    parameter int NEST_DEPTH = jsc_pkg::NEST_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [jsc_pkg::KIND_W-1:0]    i_kind,
    input  logic [jsc_pkg::PAYLOAD_W-1:0] i_payload,
    input  logic [jsc_pkg::OFFSET_W-1:0]  i_offset,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [jsc_pkg::EVENT_W-1:0]   o_event_res,
    output logic [jsc_pkg::PAYLOAD_W-1:0] o_value_out,
    output logic [jsc_pkg::ERROR_W-1:0]   o_error,
    output logic [jsc_pkg::OFFSET_W-1:0]  o_error_offset,
    output logic                          o_done_res,
    output logic [jsc_pkg::DEPTH_W-1:0]   o_depth
);
    import jsc_pkg::*;

    localparam int CNT_W = $clog2(NEST_DEPTH + 1);

    // Input register: holds one token so a new beat is taken while a result waits
    logic                 r_in_valid;
    logic [KIND_W-1:0]    r_kind;
    logic [PAYLOAD_W-1:0] r_payload;
    logic [OFFSET_W-1:0]  r_offset;

    // Parse state, advanced once per token
    t_pstate              r_pstate;

    // Result register
    logic                 r_out_valid;
    logic [EVENT_W-1:0]   r_event;
    logic [PAYLOAD_W-1:0] r_value;
    logic [ERROR_W-1:0]   r_error;
    logic [OFFSET_W-1:0]  r_err_off;
    logic                 r_done;
    logic [DEPTH_W-1:0]   r_depth;

    logic                 w_adv;
    t_dec_res             w_dec;
    t_stk_stat            w_stat;
    t_stk_op              w_op;
    logic [CNT_W-1:0]     w_count_next;

    // Advance the held token whenever the result slot is free or being drained
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    jsc_decode u_decode (
        .i_kind   (r_kind),
        .i_pstate (r_pstate),
        .i_stat   (w_stat),
        .o_res    (w_dec)
    );

    // Only touch the stack on the cycle the token is consumed
    assign w_op.push     = w_dec.op.push && w_adv;
    assign w_op.pop      = w_dec.op.pop && w_adv;
    assign w_op.push_bit = w_dec.op.push_bit;

    jsc_stack #(
        .NEST_DEPTH (NEST_DEPTH),
        .CNT_W      (CNT_W)
    ) u_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_op),
        .o_stat       (w_stat),
        .o_count_next (w_count_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pstate    <= PS_EV;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_pstate    <= w_dec.nxt;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset, loaded on beat
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind    <= i_kind;
            r_payload <= i_payload;
            r_offset  <= i_offset;
        end
        if (w_adv) begin
            r_event   <= w_dec.ev;
            r_error   <= w_dec.err;
            r_value   <= ((w_dec.ev == EV_INT) || (w_dec.ev == EV_FLOAT)) ? r_payload : '0;
            r_err_off <= (w_dec.err != ERR_OK) ? r_offset : '0;
            r_done    <= (w_dec.nxt == PS_DONE);
            r_depth   <= DEPTH_W'(w_count_next);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_event;
    assign o_value_out    = r_value;
    assign o_error        = r_error;
    assign o_error_offset = r_err_off;
    assign o_done_res     = r_done;
    assign o_depth        = r_depth;

endmodule

@@ rtl/core/jsc_checker.sv @@
module jsc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [jsc_pkg::EVENT_W-1:0]   o_event_res,
    input logic [jsc_pkg::PAYLOAD_W-1:0] o_value_out,
    input logic [jsc_pkg::ERROR_W-1:0]   o_error,
    input logic [jsc_pkg::OFFSET_W-1:0]  o_error_offset,
    input logic                          o_done_res,
    input logic [jsc_pkg::DEPTH_W-1:0]   o_depth
);
    import jsc_pkg::*;

    // A failing token raises no event and carries its offset only then
    a_err_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_error != ERR_OK) |-> (o_event_res == EV_NONE))
        else $error("event raised together with an error");

    a_ok_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_error == ERR_OK) |-> (o_error_offset == '0))
        else $error("error offset set on a clean token");

    a_value_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res != EV_INT) && (o_event_res != EV_FLOAT)
        |-> (o_value_out == '0))
        else $error("value passed through on a non-number event");

    // A finished document has closed every level
    a_done_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> (o_depth == '0))
        else $error("done reported with open nesting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_res)
        && $stable(o_error) && $stable(o_depth))
        else $error("result beat changed while stalled");

endmodule

bind json_syntax_checker_top jsc_checker u_jsc_checker (.*);

@@ test/json_syntax_checker_top_tb.sv @@
`timescale 1ns / 1ps

module json_syntax_checker_top_tb;

    import jsc_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 10;
    localparam int NEST_LEVELS  = NEST_DEPTH_DEF;
    // Two register stages between the token beat and its result beat.
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_TOKENS   = 780;
    localparam int PRESSURE_TOKENS = 40;

    // Token codes the lexer should never produce; the checker must flag them.
    localparam logic [KIND_W-1:0] KIND_BAD_LO = 4'd14;
    localparam logic [KIND_W-1:0] KIND_BAD_HI = 4'd15;

    // Shadow of the grammar state: parse state, one bit per nesting level
    // (object or array) and the current depth.
    typedef struct packed {
        t_pstate                state;
        logic [NEST_LEVELS-1:0] bits;
        logic [DEPTH_W-1:0]     count;
    } t_parse_ctx;

    // One result beat as the block should present it.
    typedef struct packed {
        t_event               ev;
        logic [PAYLOAD_W-1:0] value;
        t_error               err;
        logic [OFFSET_W-1:0]  err_off;
        logic                 done;
        logic [DEPTH_W-1:0]   depth;
    } t_result;

    typedef struct packed {
        t_parse_ctx ctx;
        t_result    res;
    } t_step;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [KIND_W-1:0]    i_kind      = '0;
    logic [PAYLOAD_W-1:0] i_payload   = '0;
    logic [OFFSET_W-1:0]  i_offset    = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [EVENT_W-1:0]   o_event_res;
    logic [PAYLOAD_W-1:0] o_value_out;
    logic [ERROR_W-1:0]   o_error;
    logic [OFFSET_W-1:0]  o_error_offset;
    logic                 o_done_res;
    logic [DEPTH_W-1:0]   o_depth;

    t_parse_ctx parser_model;
    t_result    pending_results[$];

    int mismatch_count  = 0;
    int tokens_sent     = 0;
    int results_checked = 0;
    int error_results   = 0;
    int deepest_nesting = 0;
    int cycle_count     = 0;

    // Sender pacing and the nesting depth the grammar walker aims for.
    int burst_left   = 0;
    bit gaps_enabled = 1'b1;
    int depth_cap    = 6;

    // Receiver stall pattern, plus one long hold-off on request.
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int rx_mode   = 0;
    int mode_left = 0;

    json_syntax_checker_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_payload      (i_payload),
        .i_offset       (i_offset),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_res    (o_event_res),
        .o_value_out    (o_value_out),
        .o_error        (o_error),
        .o_error_offset (o_error_offset),
        .o_done_res     (o_done_res),
        .o_depth        (o_depth)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Grammar predictor: apply one token to a copy of the parser state and
    // return the new state together with the result beat it raises. A
    // token that errors leaves the state exactly as it was.
    // ------------------------------------------------------------------
    function automatic t_step parse_token(t_parse_ctx c, logic [KIND_W-1:0] kind,
                                          logic [PAYLOAD_W-1:0] pay,
                                          logic [OFFSET_W-1:0] off);
        t_step   s;
        t_event  ev;
        t_error  err;
        t_pstate value_next;
        t_pstate push_next;
        logic    push;
        logic    pop;
        logic    lvl;
        s          = '0;
        s.ctx      = c;
        ev         = EV_NONE;
        err        = ERR_OK;
        push       = 1'b0;
        pop        = 1'b0;
        lvl        = NEST_OBJ;
        push_next  = PS_EV;
        // Where a plain value leaves the parser, by the slot it filled.
        value_next = (c.state == PS_EV) ? PS_DONE : (c.state == PS_EOV) ? PS_MOC : PS_MAC;

        if (kind == KIND_END) begin
            if (c.state != PS_DONE) err = ERR_INSUFF;
        end else if (kind > KIND_END) begin
            err = ERR_INTERN;
        end else begin
            case (c.state)
                PS_EV, PS_EOV, PS_MAV, PS_EAV: begin
                    case (kind)
                        KIND_OBJ_OPEN: begin
                            push = 1'b1; lvl = NEST_OBJ; ev = EV_OBJ_BEGIN; push_next = PS_MOK;
                        end
                        KIND_OBJ_CLOSE: err = ERR_UCURLY;
                        KIND_ARR_OPEN: begin
                            push = 1'b1; lvl = NEST_ARR; ev = EV_ARR_BEGIN; push_next = PS_MAV;
                        end
                        KIND_ARR_CLOSE: begin
                            // Only an array still waiting for its first value may close here.
                            if (c.state == PS_MAV) begin
                                pop = 1'b1; lvl = NEST_ARR; ev = EV_ARR_END;
                            end else begin
                                err = ERR_UBRACK;
                            end
                        end
                        KIND_COMMA:     err = ERR_UCOMMA;
                        KIND_COLON:     err = ERR_UCOLON;
                        KIND_STR_BEGIN: ev = EV_STR_BEGIN;
                        default: begin
                            ev = (kind == KIND_STR_END) ? EV_STR_END : t_event'(kind - 4'd1);
                            s.ctx.state = value_next;
                        end
                    endcase
                end
                PS_MOK: begin
                    if (kind == KIND_OBJ_CLOSE) begin
                        pop = 1'b1; lvl = NEST_OBJ; ev = EV_OBJ_END;
                    end else if (kind == KIND_STR_BEGIN) begin
                        ev = EV_STR_BEGIN;
                    end else if (kind == KIND_STR_END) begin
                        ev = EV_STR_END; s.ctx.state = PS_ECOL;
                    end else if (kind == KIND_INT || kind == KIND_FLOAT) begin
                        err = ERR_XKEYCC;
                    end else begin
                        err = ERR_XKEY;
                    end
                end
                PS_EOK: begin
                    if (kind == KIND_STR_BEGIN) begin
                        ev = EV_STR_BEGIN;
                    end else if (kind == KIND_STR_END) begin
                        ev = EV_STR_END; s.ctx.state = PS_ECOL;
                    end else begin
                        err = ERR_XKEY;
                    end
                end
                PS_ECOL: begin
                    if (kind == KIND_COLON) s.ctx.state = PS_EOV;
                    else if (kind == KIND_STR_END) err = ERR_INTERN;
                    else err = ERR_XCOLON;
                end
                PS_MOC: begin
                    if (kind == KIND_COMMA) begin
                        s.ctx.state = PS_EOK;
                    end else if (kind == KIND_OBJ_CLOSE) begin
                        pop = 1'b1; lvl = NEST_OBJ; ev = EV_OBJ_END;
                    end else if (kind == KIND_STR_END) begin
                        err = ERR_INTERN;
                    end else begin
                        err = ERR_XCMCC;
                    end
                end
                PS_MAC: begin
                    if (kind == KIND_COMMA) begin
                        s.ctx.state = PS_EAV;
                    end else if (kind == KIND_ARR_CLOSE) begin
                        pop = 1'b1; lvl = NEST_ARR; ev = EV_ARR_END;
                    end else if (kind == KIND_STR_END) begin
                        err = ERR_INTERN;
                    end else begin
                        err = ERR_XCMCB;
                    end
                end
                PS_DONE: err = (kind == KIND_STR_END) ? ERR_INTERN : ERR_EXCESS;
                default: err = ERR_INTERN;
            endcase
        end

        if (push) begin
            if (c.count >= NEST_LEVELS) begin
                err = ERR_OVFL;
            end else begin
                s.ctx.bits[c.count] = lvl;
                s.ctx.count         = c.count + 1'b1;
                s.ctx.state         = push_next;
            end
        end
        if (pop) begin
            if (c.count == 0 || c.bits[c.count - 1] != lvl) begin
                err = ERR_INTERN;
            end else begin
                // Fall back to the comma slot of whatever encloses the closed level.
                s.ctx.count = c.count - 1'b1;
                if (s.ctx.count == 0) s.ctx.state = PS_DONE;
                else if (c.bits[s.ctx.count - 1] == NEST_OBJ) s.ctx.state = PS_MOC;
                else s.ctx.state = PS_MAC;
            end
        end
        if (err != ERR_OK) ev = EV_NONE;

        s.res.ev      = ev;
        s.res.value   = (ev == EV_INT || ev == EV_FLOAT) ? pay : '0;
        s.res.err     = err;
        s.res.err_off = (err != ERR_OK) ? off : '0;
        s.res.done    = (s.ctx.state == PS_DONE);
        s.res.depth   = s.ctx.count;
        return s;
    endfunction

    function automatic bit at_value_slot(t_pstate st);
        return st == PS_EV || st == PS_EOV || st == PS_MAV || st == PS_EAV;
    endfunction

    // Token that moves the document one step towards closing its innermost level.
    function automatic logic [KIND_W-1:0] pick_unwind_token(t_parse_ctx c);
        case (c.state)
            PS_MAV, PS_MAC: return KIND_ARR_CLOSE;
            PS_MOK, PS_MOC: return KIND_OBJ_CLOSE;
            PS_EOK:         return KIND_STR_END;
            PS_ECOL:        return KIND_COLON;
            default:        return KIND_NULL;
        endcase
    endfunction

    // Well-formed next token with random content. Never closes the outer
    // array, so the document stays open until the last test closes it.
    function automatic logic [KIND_W-1:0] pick_grammar_token(t_parse_ctx c);
        int roll;
        roll = $urandom_range(0, 99);
        case (c.state)
            PS_MOK: begin
                if (c.count > 1 && roll < 30) return KIND_OBJ_CLOSE;
                return (roll < 50) ? KIND_STR_BEGIN : KIND_STR_END;
            end
            PS_EOK:  return (roll < 25) ? KIND_STR_BEGIN : KIND_STR_END;
            PS_ECOL: return KIND_COLON;
            PS_MOC:  return (c.count > depth_cap || roll < 35) ? KIND_OBJ_CLOSE : KIND_COMMA;
            PS_MAC: begin
                if (c.count <= 1) return KIND_COMMA;
                return (c.count > depth_cap || roll < 35) ? KIND_ARR_CLOSE : KIND_COMMA;
            end
            default: begin
                if (c.state == PS_MAV && c.count > 1 && roll < 20) return KIND_ARR_CLOSE;
                if (c.count < depth_cap && roll < 45)
                    return roll[0] ? KIND_OBJ_OPEN : KIND_ARR_OPEN;
                // true, false, null, int, float, string begin or string end
                return KIND_W'(KIND_TRUE + $urandom_range(0, 6));
            end
        endcase
    endfunction

    function automatic logic [PAYLOAD_W-1:0] rand_payload();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [OFFSET_W-1:0] rand_offset();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one token beat, hold it until accepted, then predict.
    // Beats go out in bursts of random length; a burst may start after a
    // gap with valid low.
    // ------------------------------------------------------------------
    task automatic send_token(input logic [KIND_W-1:0] kind, input logic [PAYLOAD_W-1:0] pay,
                              input logic [OFFSET_W-1:0] off);
        t_step s;
        int    gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gaps_enabled && $urandom_range(0, 1)) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_payload  <= pay;
        i_offset   <= off;
        do @(posedge i_clk); while (!o_in_ready);

        s            = parse_token(parser_model, kind, pay, off);
        parser_model = s.ctx;
        pending_results.push_back(s.res);
        tokens_sent++;
        if (int'(s.ctx.count) > deepest_nesting) deepest_nesting = int'(s.ctx.count);
    endtask

    // Mostly grammar-driven tokens, one in ten pure noise. Noise that would
    // finish the document early is swapped for a legal token.
    task automatic send_random_token();
        logic [KIND_W-1:0] kind;
        t_step             trial;
        if ($urandom_range(0, 9) == 0) kind = KIND_W'($urandom_range(0, 15));
        else kind = pick_grammar_token(parser_model);
        trial = parse_token(parser_model, kind, '0, '0);
        if (trial.ctx.state == PS_DONE) kind = pick_grammar_token(parser_model);
        send_token(kind, rand_payload(), rand_offset());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Tokens that cannot start a document, with the offset at both extremes.
    task automatic test_top_level_errors();
        send_token(KIND_OBJ_CLOSE, '1, '1);
        send_token(KIND_ARR_CLOSE, '0, '0);
        send_token(KIND_COMMA, rand_payload(), rand_offset());
        send_token(KIND_COLON, rand_payload(), rand_offset());
        send_token(KIND_END, rand_payload(), rand_offset());
        send_token(KIND_BAD_LO, '1, '1);
        send_token(KIND_BAD_HI, rand_payload(), rand_offset());
        // A string chunk raises its event and leaves the parser where it was.
        send_token(KIND_STR_BEGIN, rand_payload(), rand_offset());
    endtask

    // Open the outer array that holds the rest of the run, then probe it.
    task automatic test_array_grammar();
        send_token(KIND_ARR_OPEN, rand_payload(), rand_offset());
        send_token(KIND_INT, '1, '0);
        send_token(KIND_COLON, rand_payload(), '1);
        send_token(KIND_STR_END, rand_payload(), rand_offset());
        send_token(KIND_COMMA, rand_payload(), rand_offset());
        // After a comma the array needs a value; a close bracket is refused.
        send_token(KIND_ARR_CLOSE, rand_payload(), rand_offset());
        send_token(KIND_FLOAT, rand_payload(), rand_offset());
        send_token(KIND_COMMA, rand_payload(), rand_offset());
    endtask

    task automatic test_object_grammar();
        send_token(KIND_OBJ_OPEN, rand_payload(), rand_offset());
        send_token(KIND_INT, rand_payload(), rand_offset());
        send_token(KIND_STR_END, rand_payload(), rand_offset());
        send_token(KIND_STR_END, rand_payload(), rand_offset());
        send_token(KIND_TRUE, rand_payload(), rand_offset());
        send_token(KIND_COLON, rand_payload(), rand_offset());
        // Empty array as an object value; closing it returns to the object's comma slot.
        send_token(KIND_ARR_OPEN, rand_payload(), rand_offset());
        send_token(KIND_ARR_CLOSE, rand_payload(), rand_offset());
        send_token(KIND_NULL, rand_payload(), rand_offset());
        send_token(KIND_STR_END, rand_payload(), rand_offset());
        send_token(KIND_COMMA, rand_payload(), rand_offset());
        send_token(KIND_OBJ_CLOSE, rand_payload(), rand_offset());
        send_token(KIND_STR_END, rand_payload(), rand_offset());
        send_token(KIND_COLON, rand_payload(), rand_offset());
        // Empty object closed straight from the key slot, then the outer object.
        send_token(KIND_OBJ_OPEN, rand_payload(), rand_offset());
        send_token(KIND_OBJ_CLOSE, rand_payload(), rand_offset());
        send_token(KIND_OBJ_CLOSE, rand_payload(), rand_offset());
    endtask

    // Nest a random mix of objects and arrays to the full stack depth, try
    // to go one deeper with both kinds of opener, then unwind to the outer array.
    task automatic test_nesting_overflow();
        logic [KIND_W-1:0] kind;
        while (!(parser_model.count == NEST_LEVELS && at_value_slot(parser_model.state))) begin
            case (parser_model.state)
                PS_MOK, PS_EOK: kind = KIND_STR_END;
                PS_ECOL:        kind = KIND_COLON;
                PS_MOC, PS_MAC: kind = KIND_COMMA;
                default:        kind = $urandom_range(0, 1) ? KIND_OBJ_OPEN : KIND_ARR_OPEN;
            endcase
            send_token(kind, rand_payload(), rand_offset());
        end
        send_token(KIND_OBJ_OPEN, rand_payload(), '1);
        send_token(KIND_ARR_OPEN, rand_payload(), rand_offset());
        while (parser_model.count > 1)
            send_token(pick_unwind_token(parser_model), rand_payload(), rand_offset());
    endtask

    task automatic test_random_documents();
        for (int n = 0; n < RANDOM_TOKENS; n++) begin
            // Re-pick the target depth and the pacing every so often.
            if (n % 60 == 0) begin
                depth_cap    = ($urandom_range(0, 7) == 0) ? 20 : $urandom_range(2, 10);
                gaps_enabled = ($urandom_range(0, 3) != 0);
            end
            send_random_token();
        end
        gaps_enabled = 1'b1;
    endtask

    // Hold the result side off for a long stretch while tokens keep coming,
    // so both registers fill and the input stalls.
    task automatic test_backpressure();
        gaps_enabled = 1'b0;
        hold_asks   <= hold_asks + 1;
        for (int n = 0; n < PRESSURE_TOKENS; n++) send_random_token();
        gaps_enabled = 1'b1;
    endtask

    // Close the document, then check end of input, excess tokens and a
    // stray string end once it is complete.
    task automatic test_end_of_document();
        while (parser_model.state != PS_DONE)
            send_token(pick_unwind_token(parser_model), rand_payload(), rand_offset());
        send_token(KIND_END, rand_payload(), rand_offset());
        send_token(KIND_TRUE, rand_payload(), rand_offset());
        send_token(KIND_STR_END, rand_payload(), rand_offset());
        send_token(KIND_OBJ_OPEN, rand_payload(), '1);
        send_token(KIND_END, rand_payload(), rand_offset());
        i_in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: a stall pattern that changes mode at random, overridden by
    // the long hold-off whenever one is requested.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen   <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= $urandom_range(0, 3);
                mode_left <= $urandom_range(16, 160);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ~i_out_ready;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare every accepted result beat with the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    function automatic void check_field(string label, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (o_error != ERR_OK) error_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with no token pending, expected nothing, got event %0d error %0d",
                         $time, o_event_res, o_error);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("event", 64'(want.ev), 64'(o_event_res));
                check_field("value", want.value, o_value_out);
                check_field("error", 64'(want.err), 64'(o_error));
                check_field("error offset", 64'(want.err_off), 64'(o_error_offset));
                check_field("done", 64'(want.done), 64'(o_done_res));
                check_field("depth", 64'(want.depth), 64'(o_depth));
            end
        end
    end

    // Watchdog: end the run if it stops making progress.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        parser_model       = '0;
        parser_model.state = PS_EV;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_top_level_errors();
        test_array_grammar();
        test_object_grammar();
        test_nesting_overflow();
        test_random_documents();
        test_backpressure();
        test_end_of_document();

        // Drain: wait for every prediction, then watch for stray result beats.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d tokens, checked %0d results, %0d of them reporting errors.",
                 tokens_sent, results_checked, error_results);
        $display("Deepest nesting reached %0d of %0d levels; %0d mismatches.",
                 deepest_nesting, NEST_LEVELS, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
